/* rtl/irs_pkg.sv */
// shared types and constants for the image resize scaler
package irs_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_DST_WIDTH   = 3'd2;
	localparam logic [2:0] REG_DST_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_SAMPLE_MODE = 3'd4;
	localparam logic [2:0] REG_PIXEL_BYTES = 3'd5;

	// item kinds carried in tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// sample modes
	localparam logic MODE_NEAREST = 1'b0;

	localparam logic [2:0] PIXEL_BYTES_RGB = 3'd3;

	localparam int unsigned DST_MAX = 4096;

	typedef logic [7:0] chan_t;

endpackage

/* rtl/irs_ram.sv */
// generic single-port ram with registered read
module irs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/irs_div.sv */
// iterative restoring divider, one quotient bit per cycle
module irs_div #(
	parameter int unsigned NW = 25,
	parameter int unsigned DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : DW'(trial);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

endmodule

/* rtl/image_resize_scaler_core.sv */
// top level of the image resize scaler: frame store, step ratios and sampler
//
//  channel  dir  transfer on            contents
//  s_*      in   s_tvalid & s_tready    tuser opcode; tdata col, row, pixel_in
//  m_*      out  m_tvalid & m_tready    tdata pixel_out, out_col, out_row
//  cfg_*    in   cfg_we                 register index and value, no read-back
//
// a load writes the frame store in the transfer cycle
// sampling makes two passes through the shared multiplier for the position; nearest
// then reads one pixel, bilinear does four read/weight and accumulate pairs on
// the single-port frame store
// after reset and after any size write the x and y steps are divided out one
// bit a cycle, x step then y step, and s_tready stays low while they are divided out
// a finished result waits in the output register; a new item is taken while it
// waits, and a later sample stalls in its last step until the register is free
module image_resize_scaler_core #(
	parameter int unsigned MAX_SRC_WIDTH  = 256,
	parameter int unsigned MAX_SRC_HEIGHT = 256,
	parameter int unsigned FRAC_BITS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // col [11:0], row [23:12], pixel_in [55:24]
	input  logic [0:0]  s_tuser,   // opcode
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pixel_out [31:0], out_col [43:32], out_row [55:44]
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);

	localparam int unsigned F     = FRAC_BITS;
	localparam int unsigned QW    = 9 + F;                  // step width
	localparam int unsigned MA    = (F + 1 > 12) ? F + 1 : 12;
	localparam int unsigned PW    = MA + QW;                // multiplier product
	localparam int unsigned POSW  = 21 + F;                 // col times step
	localparam int unsigned WW    = 2 * F + 1;              // weight width
	localparam int unsigned ACCW  = 2 * F + 9;
	localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);

	// configuration registers
	logic [8:0]  src_width_q, src_height_q;
	logic [12:0] dst_width_q, dst_height_q;
	logic        sample_mode_q;
	logic [2:0]  pixel_bytes_q;

	// sizes saturated to their legal ranges
	logic [8:0]  sw, sh;
	logic [12:0] dw, dh;

	always_comb begin
		sw = (src_width_q == '0) ? 9'd1 :
			(13'(src_width_q) > 13'(MAX_SRC_WIDTH)) ? 9'(MAX_SRC_WIDTH) : src_width_q;
		sh = (src_height_q == '0) ? 9'd1 :
			(13'(src_height_q) > 13'(MAX_SRC_HEIGHT)) ? 9'(MAX_SRC_HEIGHT) : src_height_q;
		dw = (dst_width_q == '0) ? 13'd1 :
			(dst_width_q > 13'(irs_pkg::DST_MAX)) ? 13'(irs_pkg::DST_MAX) : dst_width_q;
		dh = (dst_height_q == '0) ? 13'd1 :
			(dst_height_q > 13'(irs_pkg::DST_MAX)) ? 13'(irs_pkg::DST_MAX) : dst_height_q;
	end

	// any size write asks for fresh steps
	logic size_write;
	assign size_write = cfg_we && (cfg_index == irs_pkg::REG_SRC_WIDTH ||
		cfg_index == irs_pkg::REG_SRC_HEIGHT || cfg_index == irs_pkg::REG_DST_WIDTH ||
		cfg_index == irs_pkg::REG_DST_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q   <= 9'd256;
			src_height_q  <= 9'd256;
			dst_width_q   <= 13'd256;
			dst_height_q  <= 13'd256;
			sample_mode_q <= 1'b1;
			pixel_bytes_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				irs_pkg::REG_SRC_WIDTH:   src_width_q   <= cfg_wdata[8:0];
				irs_pkg::REG_SRC_HEIGHT:  src_height_q  <= cfg_wdata[8:0];
				irs_pkg::REG_DST_WIDTH:   dst_width_q   <= cfg_wdata;
				irs_pkg::REG_DST_HEIGHT:  dst_height_q  <= cfg_wdata;
				irs_pkg::REG_SAMPLE_MODE: sample_mode_q <= cfg_wdata[0];
				irs_pkg::REG_PIXEL_BYTES: pixel_bytes_q <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// step ratio sequencer: x step then y step through one divider
	typedef enum logic [1:0] {STEP_IDLE, STEP_X, STEP_Y} step_state_t;

	step_state_t      step_state_q;
	logic             step_req_q;
	logic             div_start, div_done;
	logic [QW-1:0]    div_dividend, div_quotient;
	logic [12:0]      div_divisor;
	logic [QW-1:0]    x_step_q, y_step_q;
	logic             steps_busy;

	assign div_start    = (step_state_q == STEP_IDLE && step_req_q) ||
		(step_state_q == STEP_X && div_done);
	assign div_dividend = (step_state_q == STEP_IDLE) ? {sw, F'(0)} : {sh, F'(0)};
	assign div_divisor  = (step_state_q == STEP_IDLE) ? dw : dh;
	assign steps_busy   = step_req_q || step_state_q != STEP_IDLE;

	irs_div #(.NW(QW), .DW(13)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_state_q <= STEP_IDLE;
			step_req_q   <= 1'b1;
			x_step_q     <= '0;
			y_step_q     <= '0;
		end else begin
			case (step_state_q)
				STEP_IDLE: begin
					if (step_req_q) begin
						step_req_q   <= 1'b0;
						step_state_q <= STEP_X;
					end
				end
				STEP_X: begin
					if (div_done) begin
						x_step_q     <= div_quotient;
						step_state_q <= STEP_Y;
					end
				end
				STEP_Y: begin
					if (div_done) begin
						y_step_q     <= div_quotient;
						step_state_q <= STEP_IDLE;
					end
				end
				default: step_state_q <= STEP_IDLE;
			endcase
			if (size_write) begin
				step_req_q <= 1'b1;
			end
		end
	end

	// sample sequencer
	typedef enum logic [2:0] {
		S_IDLE, S_MULX, S_MULY, S_READ, S_ACC, S_NREAD, S_NDATA, S_OUT
	} state_t;

	state_t        state_q;
	logic [1:0]    nb_q;               // neighbour being fetched
	logic [11:0]   col_q, row_q;
	logic [POSW-1:0] pos_x_q, pos_y_q;
	logic [WW-1:0] w_q;
	logic [ACCW-1:0] acc_q [4];
	logic [31:0]   res_q;
	logic          m_valid_q;
	logic [55:0]   m_data_q;

	logic          in_xfer, out_free;
	assign s_tready = state_q == S_IDLE && !steps_busy;
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// shared multiplier
	logic [MA-1:0] mul_a;
	logic [QW-1:0] mul_b;
	logic [PW-1:0] mul_p;
	logic [F:0]    one, fx_w, fy_w;

	assign one  = {1'b1, F'(0)};
	assign fx_w = nb_q[0] ? {1'b0, pos_x_q[F-1:0]} : one - {1'b0, pos_x_q[F-1:0]};
	assign fy_w = nb_q[1] ? {1'b0, pos_y_q[F-1:0]} : one - {1'b0, pos_y_q[F-1:0]};

	always_comb begin
		case (state_q)
			S_MULX: begin
				mul_a = MA'(col_q);
				mul_b = x_step_q;
			end
			S_MULY: begin
				mul_a = MA'(row_q);
				mul_b = y_step_q;
			end
			default: begin
				mul_a = MA'(fx_w);
				mul_b = QW'(fy_w);
			end
		endcase
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// integer positions clamped to the source, far neighbours likewise
	logic [20:0] ipx, ipy;
	logic [8:0]  x0, y0, x1, y1, cx, cy;
	logic [9:0]  x0n, y0n;

	always_comb begin
		ipx = pos_x_q[POSW-1:F];
		ipy = pos_y_q[POSW-1:F];
		x0  = (ipx >= 21'(sw)) ? sw - 1'b1 : ipx[8:0];
		y0  = (ipy >= 21'(sh)) ? sh - 1'b1 : ipy[8:0];
		x0n = 10'(x0) + 10'd1;
		y0n = 10'(y0) + 10'd1;
		x1  = (x0n >= 10'(sw)) ? sw - 1'b1 : x0n[8:0];
		y1  = (y0n >= 10'(sh)) ? sh - 1'b1 : y0n[8:0];
		cx  = (state_q == S_READ && nb_q[0]) ? x1 : x0;
		cy  = (state_q == S_READ && nb_q[1]) ? y1 : y0;
	end

	// frame store port: loads write in the transfer cycle
	logic [11:0] in_col, in_row;
	logic [31:0] in_pixel;
	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0] ram_rdata;

	assign in_col   = s_tdata[11:0];
	assign in_row   = s_tdata[23:12];
	assign in_pixel = s_tdata[55:24];
	assign ram_we   = in_xfer && s_tuser[0] == irs_pkg::OP_LOAD &&
		in_col < 12'(sw) && in_row < 12'(sh);
	assign ram_addr = (state_q == S_IDLE) ?
		AW'(AW'(in_row) * AW'(MAX_SRC_WIDTH) + AW'(in_col)) :
		AW'(AW'(cy) * AW'(MAX_SRC_WIDTH) + AW'(cx));

	irs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_pixel),
		.rdata (ram_rdata)
	);

	// blended channels
	logic [31:0] blend;
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			blend[8*c +: 8] = acc_q[c][2*F +: 8];
		end
	end

	// the bilinear sum is complete once the last accumulate has landed
	logic [31:0] pix_res;
	assign pix_res = (sample_mode_q == irs_pkg::MODE_NEAREST) ? res_q : blend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			nb_q      <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && s_tuser[0] == irs_pkg::OP_SAMPLE) begin
						state_q <= S_MULX;
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: begin
					nb_q    <= '0;
					state_q <= (sample_mode_q == irs_pkg::MODE_NEAREST) ? S_NREAD : S_READ;
				end
				S_READ: state_q <= S_ACC;
				S_ACC: begin
					nb_q    <= nb_q + 1'b1;
					state_q <= (nb_q == 2'd3) ? S_OUT : S_READ;
				end
				S_NREAD: state_q <= S_NDATA;
				S_NDATA: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q <= in_col;
			row_q <= in_row;
		end
		case (state_q)
			S_MULX: pos_x_q <= mul_p[POSW-1:0];
			S_MULY: begin
				pos_y_q <= mul_p[POSW-1:0];
				for (int c = 0; c < 4; c++) begin
					acc_q[c] <= '0;
				end
			end
			S_READ: w_q <= mul_p[WW-1:0];
			S_ACC: begin
				for (int c = 0; c < 4; c++) begin
					acc_q[c] <= acc_q[c] + ACCW'(w_q) * ACCW'(ram_rdata[8*c +: 8]);
				end
			end
			S_NDATA: res_q <= ram_rdata;
			S_OUT: begin
				if (out_free) begin
					m_data_q[31:0]  <= (pixel_bytes_q == irs_pkg::PIXEL_BYTES_RGB) ?
						{8'd0, pix_res[23:0]} : pix_res;
					m_data_q[43:32] <= col_q;
					m_data_q[55:44] <= row_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
